[rtl/core/rwl_pkg.sv]
// Shared constants, codes and control types of the reader-writer lock arbiter.
// Used by every file of the block but rwl_ram; depends on nothing.
package rwl_pkg;

    localparam int NUM_TASKS     = 16;
    localparam int MAX_RECURSION = 255;

    localparam int TASK_W    = 4;
    localparam int TASK_SPAN = 2 ** TASK_W;
    localparam int CMD_W     = 2;
    localparam int EVENT_W   = 3;
    localparam int COUNT_W   = 5;
    localparam int COUNT_MAX = 2 ** COUNT_W - 1;
    localparam int QIDX_W    = $clog2(NUM_TASKS);
    localparam int QFILL_W   = $clog2(NUM_TASKS + 1);
    localparam int DEPTH_W   = $clog2(MAX_RECURSION + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SH_ACQUIRE = 2'd0,
        CMD_SH_RELEASE = 2'd1,
        CMD_EX_ACQUIRE = 2'd2,
        CMD_EX_RELEASE = 2'd3
    } t_command;

    typedef enum logic [EVENT_W-1:0] {
        EV_GRANT = 3'd0,
        EV_WAIT  = 3'd1,
        EV_DONE  = 3'd2,
        EV_ERROR = 3'd3,
        EV_WOKEN = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_HANDOFF,
        ST_WAKE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic apply;
        logic emit_woken;
        logic wake_step;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic handoff;
        logic wake;
        logic wake_last;
        logic owner_held;
        logic readers_held;
        logic queue_busy;
    } t_dp_status;

endpackage

[rtl/core/rwl_ifs.sv]
// Handshake channels of the lock arbiter: request, result and configuration.
// Depends on rwl_pkg for the field widths.
interface rwl_req_if;
    logic                         valid;
    logic                         ready;
    logic [rwl_pkg::CMD_W-1:0]    command;
    logic [rwl_pkg::TASK_W-1:0]   requester;

    modport source (output valid, output command, output requester, input ready);
    modport sink   (input valid, input command, input requester, output ready);
endinterface

interface rwl_res_if;
    logic                         valid;
    logic                         ready;
    logic [rwl_pkg::EVENT_W-1:0]  event_res;
    logic [rwl_pkg::TASK_W-1:0]   task_res;
    logic                         last;

    modport source (output valid, output event_res, output task_res, output last,
                    input ready);
    modport sink   (input valid, input event_res, input task_res, input last,
                    output ready);
endinterface

interface rwl_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/rwl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the waiting-writer queue.
module rwl_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rwl_ctl.sv]
// Sequencing state machine of the lock arbiter.
// Depends on rwl_pkg; drives the datapath through t_ctl_cmd.
module rwl_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  rwl_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output rwl_pkg::t_ctl_cmd   o_cmd
);

    rwl_pkg::t_state r_state;
    rwl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwl_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = rwl_pkg::ST_DECIDE;
                end
            end
            rwl_pkg::ST_DECIDE: begin
                if (i_status.out_free) begin
                    if (i_status.handoff) begin
                        n_state = rwl_pkg::ST_HANDOFF;
                    end else if (i_status.wake) begin
                        n_state = rwl_pkg::ST_WAKE;
                    end else begin
                        n_state = rwl_pkg::ST_IDLE;
                    end
                end
            end
            rwl_pkg::ST_HANDOFF: begin
                if (i_status.out_free) begin
                    n_state = rwl_pkg::ST_IDLE;
                end
            end
            rwl_pkg::ST_WAKE: begin
                if (i_status.out_free && i_status.wake_last) begin
                    n_state = rwl_pkg::ST_IDLE;
                end
            end
            default: n_state = rwl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            rwl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_req_valid;
            end
            rwl_pkg::ST_DECIDE:  o_cmd.apply      = i_status.out_free;
            rwl_pkg::ST_HANDOFF: o_cmd.emit_woken = i_status.out_free;
            rwl_pkg::ST_WAKE:    o_cmd.wake_step  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/core/rwl_datapath.sv]
// Lock state, request decoder, writer queue and result register.
// Depends on rwl_pkg and rwl_ram; commanded by rwl_ctl.
module rwl_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rwl_pkg::t_ctl_cmd           i_cmd,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic [rwl_pkg::CMD_W-1:0]   i_command,
    input  logic [rwl_pkg::TASK_W-1:0]  i_requester,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [rwl_pkg::EVENT_W-1:0] o_event_res,
    output logic [rwl_pkg::TASK_W-1:0]  o_task_res,
    output logic                        o_last,
    output rwl_pkg::t_dp_status         o_status
);

    typedef enum logic [3:0] {
        ACT_ERROR,
        ACT_RD_GRANT,
        ACT_RD_WAIT,
        ACT_RD_DONE,
        ACT_RD_HANDOFF,
        ACT_WR_REGRANT,
        ACT_WR_GRANT,
        ACT_WR_WAIT,
        ACT_WR_DEPTH,
        ACT_WR_FREE,
        ACT_WR_HANDOFF,
        ACT_WR_WAKE
    } t_action;

    logic                          r_rec_mode;
    rwl_pkg::t_command             r_req_cmd;
    logic [rwl_pkg::TASK_W-1:0]    r_req_task;
    logic [rwl_pkg::COUNT_W-1:0]   r_rc;
    logic [rwl_pkg::COUNT_W-1:0]   r_wc;
    logic                          r_owner_valid;
    logic [rwl_pkg::TASK_W-1:0]    r_owner_task;
    logic [rwl_pkg::DEPTH_W-1:0]   r_depth;
    logic [rwl_pkg::QIDX_W-1:0]    r_head;
    logic [rwl_pkg::QFILL_W-1:0]   r_fill;
    logic [rwl_pkg::TASK_SPAN-1:0] r_waiting;
    logic [rwl_pkg::TASK_SPAN-1:0] r_queued;
    logic                          r_out_valid;
    rwl_pkg::t_event               r_out_event;
    logic [rwl_pkg::TASK_W-1:0]    r_out_task;
    logic                          r_out_last;

    t_action                       act;
    logic                          blocked;
    logic                          is_owner;
    logic                          queue_full;
    logic [rwl_pkg::DEPTH_W-1:0]   depth_base;
    logic [rwl_pkg::QIDX_W:0]      tail_sum;
    logic [rwl_pkg::QIDX_W-1:0]    tail;
    logic [rwl_pkg::QIDX_W-1:0]    head_next;
    logic [rwl_pkg::TASK_W-1:0]    head_task;
    logic                          pop;
    logic [rwl_pkg::TASK_W-1:0]    wake_idx;
    logic [rwl_pkg::TASK_SPAN-1:0] wake_rest;
    logic                          wake_last;
    rwl_pkg::t_event               first_event;
    logic                          first_last;
    logic                          emit;

    // The queue is read at the head every cycle; the registered word is
    // current by the decide step because nothing is written on the accept edge.
    rwl_ram #(
        .WIDTH (rwl_pkg::TASK_W),
        .DEPTH (rwl_pkg::NUM_TASKS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.apply && (act == ACT_WR_WAIT)),
        .i_waddr (tail),
        .i_wdata (r_req_task),
        .i_raddr (r_head),
        .o_rdata (head_task)
    );

    assign tail_sum  = (rwl_pkg::QIDX_W+1)'(r_head) + (rwl_pkg::QIDX_W+1)'(r_fill);
    assign tail      = (int'(tail_sum) >= rwl_pkg::NUM_TASKS)
                     ? rwl_pkg::QIDX_W'(int'(tail_sum) - rwl_pkg::NUM_TASKS)
                     : rwl_pkg::QIDX_W'(tail_sum);
    assign head_next = (int'(r_head) == rwl_pkg::NUM_TASKS - 1)
                     ? '0 : r_head + 1'b1;

    assign blocked    = r_waiting[r_req_task] || r_queued[r_req_task]
                     || (int'(r_req_task) >= rwl_pkg::NUM_TASKS);
    assign is_owner   = r_owner_valid && (r_owner_task == r_req_task);
    assign queue_full = int'(r_fill) >= rwl_pkg::NUM_TASKS;
    assign depth_base = (r_depth == '0) ? rwl_pkg::DEPTH_W'(1) : r_depth;

    // Request decoder.
    always_comb begin
        act = ACT_ERROR;
        if (!blocked) begin
            unique case (r_req_cmd)
                rwl_pkg::CMD_SH_ACQUIRE: begin
                    if (r_wc != '0) begin
                        act = ACT_RD_WAIT;
                    end else if (int'(r_rc) == rwl_pkg::COUNT_MAX) begin
                        act = ACT_ERROR;
                    end else begin
                        act = ACT_RD_GRANT;
                    end
                end
                rwl_pkg::CMD_SH_RELEASE: begin
                    if (r_rc == '0) begin
                        act = ACT_ERROR;
                    end else if (r_rc == rwl_pkg::COUNT_W'(1) && r_wc != '0
                                 && r_fill != '0 && !r_owner_valid) begin
                        act = ACT_RD_HANDOFF;
                    end else begin
                        act = ACT_RD_DONE;
                    end
                end
                rwl_pkg::CMD_EX_ACQUIRE: begin
                    if (is_owner) begin
                        if (!r_rec_mode || int'(depth_base) >= rwl_pkg::MAX_RECURSION) begin
                            act = ACT_ERROR;
                        end else begin
                            act = ACT_WR_REGRANT;
                        end
                    end else if (int'(r_wc) == rwl_pkg::COUNT_MAX || queue_full) begin
                        act = ACT_ERROR;
                    end else if (!r_owner_valid && r_rc == '0 && r_fill == '0) begin
                        act = ACT_WR_GRANT;
                    end else begin
                        act = ACT_WR_WAIT;
                    end
                end
                rwl_pkg::CMD_EX_RELEASE: begin
                    if (!is_owner) begin
                        act = ACT_ERROR;
                    end else if (r_rec_mode && r_depth > rwl_pkg::DEPTH_W'(1)) begin
                        act = ACT_WR_DEPTH;
                    end else if (r_fill != '0) begin
                        act = ACT_WR_HANDOFF;
                    end else if (r_waiting == '0) begin
                        act = ACT_WR_FREE;
                    end else begin
                        act = ACT_WR_WAKE;
                    end
                end
                default: act = ACT_ERROR;
            endcase
        end
    end

    always_comb begin
        case (act) inside
            ACT_ERROR: first_event = rwl_pkg::EV_ERROR;
            ACT_RD_GRANT, ACT_WR_GRANT, ACT_WR_REGRANT: first_event = rwl_pkg::EV_GRANT;
            ACT_RD_WAIT, ACT_WR_WAIT: first_event = rwl_pkg::EV_WAIT;
            default: first_event = rwl_pkg::EV_DONE;
        endcase
    end

    assign first_last = !((act == ACT_RD_HANDOFF) || (act == ACT_WR_HANDOFF)
                       || (act == ACT_WR_WAKE));
    assign pop        = i_cmd.apply && ((act == ACT_RD_HANDOFF) || (act == ACT_WR_HANDOFF));

    // Lowest waiting reader is woken first.
    always_comb begin
        wake_idx = '0;
        for (int i = rwl_pkg::TASK_SPAN - 1; i >= 0; i--) begin
            if (r_waiting[i]) begin
                wake_idx = rwl_pkg::TASK_W'(i);
            end
        end
    end

    assign wake_rest = r_waiting & (r_waiting - 1'b1);
    assign wake_last = (wake_rest == '0);

    assign emit = i_cmd.apply || i_cmd.emit_woken || i_cmd.wake_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_mode    <= 1'b0;
            r_rc          <= '0;
            r_wc          <= '0;
            r_owner_valid <= 1'b0;
            r_owner_task  <= '0;
            r_depth       <= '0;
            r_head        <= '0;
            r_fill        <= '0;
            r_waiting     <= '0;
            r_queued      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_mode <= i_cfg_data;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.apply) begin
                case (act) inside
                    ACT_RD_GRANT: r_rc <= r_rc + 1'b1;
                    ACT_RD_WAIT:  r_waiting[r_req_task] <= 1'b1;
                    ACT_RD_DONE, ACT_RD_HANDOFF: r_rc <= r_rc - 1'b1;
                    ACT_WR_REGRANT: r_depth <= depth_base + 1'b1;
                    ACT_WR_GRANT: begin
                        r_wc          <= r_wc + 1'b1;
                        r_owner_valid <= 1'b1;
                        r_owner_task  <= r_req_task;
                        r_depth       <= rwl_pkg::DEPTH_W'(r_rec_mode);
                    end
                    ACT_WR_WAIT: begin
                        r_wc                 <= r_wc + 1'b1;
                        r_fill               <= r_fill + 1'b1;
                        r_queued[r_req_task] <= 1'b1;
                    end
                    ACT_WR_DEPTH: r_depth <= r_depth - 1'b1;
                    ACT_WR_FREE, ACT_WR_WAKE: begin
                        r_owner_valid <= 1'b0;
                        r_owner_task  <= '0;
                        r_depth       <= '0;
                        if (r_wc != '0) begin
                            r_wc <= r_wc - 1'b1;
                        end
                    end
                    ACT_WR_HANDOFF: begin
                        if (r_wc != '0) begin
                            r_wc <= r_wc - 1'b1;
                        end
                    end
                    default: ;
                endcase
                // An atomic hand-off passes ownership straight to the head writer.
                if (pop) begin
                    r_owner_valid       <= 1'b1;
                    r_owner_task        <= head_task;
                    r_depth             <= rwl_pkg::DEPTH_W'(r_rec_mode);
                    r_head              <= head_next;
                    r_fill              <= r_fill - 1'b1;
                    r_queued[head_task] <= 1'b0;
                end
            end

            if (i_cmd.wake_step) begin
                r_waiting <= wake_rest;
                if (int'(r_rc) != rwl_pkg::COUNT_MAX) begin
                    r_rc <= r_rc + 1'b1;
                end
            end
        end
    end

    // Request and result payloads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req_cmd  <= rwl_pkg::t_command'(i_command);
            r_req_task <= i_requester;
        end
        if (i_cmd.apply) begin
            r_out_event <= first_event;
            r_out_task  <= r_req_task;
            r_out_last  <= first_last;
        end else if (i_cmd.emit_woken) begin
            r_out_event <= rwl_pkg::EV_WOKEN;
            r_out_task  <= r_owner_task;
            r_out_last  <= 1'b1;
        end else if (i_cmd.wake_step) begin
            r_out_event <= rwl_pkg::EV_WOKEN;
            r_out_task  <= wake_idx;
            r_out_last  <= wake_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_event;
    assign o_task_res  = r_out_task;
    assign o_last      = r_out_last;

    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_status.handoff      = (act == ACT_RD_HANDOFF) || (act == ACT_WR_HANDOFF);
    assign o_status.wake         = (act == ACT_WR_WAKE);
    assign o_status.wake_last    = wake_last;
    assign o_status.owner_held   = r_owner_valid;
    assign o_status.readers_held = (r_rc != '0);
    assign o_status.queue_busy   = (r_fill != '0);

endmodule

[rtl/core/writer_preferring_rwlock_arbiter.sv]
// Top level of the writer-preferring reader-writer lock arbiter.
// Depends on rwl_pkg, the rwl_ifs channels, rwl_ctl, rwl_datapath and rwl_ram.
//
//   Channel   Direction  Payload                          Handshake
//   i_req     in         command, requester               valid / ready
//   o_res     out        event_res, task_res, last        valid / ready
//   i_cfg     in         data (recursive mode)            valid / ready (always ready)
//
// An item is accepted in the idle state and then decided in the decide state; each
// further result of a release (the woken writer, or each woken reader in ascending
// task order) is emitted from the hand-off or the wake state.
// The decide step and every later result wait while the output register is full
// and not taken; the next item can be accepted while the last result is waiting.
// Reset is synchronous and active low; it clears all lock state and needs no
// clearing pass, since the writer queue is only read at entries written before.
module writer_preferring_rwlock_arbiter (
    input logic     i_clk,
    input logic     i_rst_n,
    rwl_req_if.sink i_req,
    rwl_res_if.source o_res,
    rwl_cfg_if.sink i_cfg
);

    rwl_pkg::t_ctl_cmd   ctl_cmd;
    rwl_pkg::t_dp_status dp_status;
    logic                in_ready;

    // The configuration register takes a write in any cycle.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = in_ready;

    // The controller walks accept, decide and the run of extra results.
    rwl_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (dp_status),
        .o_in_ready  (in_ready),
        .o_cmd       (ctl_cmd)
    );

    // The datapath holds the counts, owner, queue and waiting-reader bitmap.
    rwl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_command   (i_req.command),
        .i_requester (i_req.requester),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_event_res (o_res.event_res),
        .o_task_res  (o_res.task_res),
        .o_last      (o_res.last),
        .o_status    (dp_status)
    );

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in work");

    // While a run of results is incomplete no new item is taken.
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |-> !i_req.ready)
        else $error("request accepted during a run of results");

    // A writer and readers never hold the lock together.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_status.owner_held && dp_status.readers_held))
        else $error("owner and readers hold the lock together");

    // Queued writers always wait behind a holder.
    a_queue_behind_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.queue_busy |-> (dp_status.owner_held || dp_status.readers_held))
        else $error("writers queued on a free lock");

endmodule

[dv/tb_writer_preferring_rwlock_arbiter.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the writer-preferring reader-writer lock arbiter.
// Depends on rwl_pkg, the rwl_ifs channels and the arbiter RTL; it reads no files.
module tb_writer_preferring_rwlock_arbiter;

    localparam int CLK_HALF         = 6;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PER_CHUNK = 20;
    localparam int CHUNKS           = 4;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int NEST_DEPTH       = 6;

    typedef logic [rwl_pkg::TASK_W-1:0] t_task_id;

    // One result of the lock as the block should emit it.
    typedef struct {
        rwl_pkg::t_event ev_code;
        t_task_id        who;
        logic            fin;
    } t_lock_event;

    // Keeps its own copy of the lock state, works out the results of every
    // accepted request and compares the block's results against them in order.
    class lock_scoreboard;
        bit                            recursive;
        int unsigned                   readers;
        int unsigned                   writers;
        bit                            owner_valid;
        t_task_id                      owner;
        int unsigned                   depth;
        t_task_id                      wq [rwl_pkg::NUM_TASKS];
        t_task_id                      q_head;
        int unsigned                   q_fill;
        logic [rwl_pkg::NUM_TASKS-1:0] waiting;
        t_lock_event                   lock_events_q [$];
        int unsigned                   mismatches;
        int unsigned                   requests;
        int unsigned                   results_seen;
        int unsigned                   errors_seen;
        int unsigned                   widest;

        function new();
            recursive   = 1'b0;
            readers     = 0;
            writers     = 0;
            owner_valid = 1'b0;
            owner       = '0;
            depth       = 0;
            foreach (wq[i]) wq[i] = '0;
            q_head      = '0;
            q_fill      = 0;
            waiting     = '0;
            mismatches  = 0;
            requests    = 0;
            results_seen = 0;
            errors_seen = 0;
            widest      = 0;
        endfunction

        function int unsigned pending();
            return lock_events_q.size();
        endfunction

        function bit queued(t_task_id t);
            for (int unsigned i = 0; i < q_fill; i++) begin
                if (wq[rwl_pkg::TASK_W'(q_head + i)] == t) return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit blocked(t_task_id t);
            return waiting[t] || queued(t);
        endfunction

        function void push(rwl_pkg::t_event ev, t_task_id who, logic fin);
            t_lock_event e;
            e.ev_code = ev;
            e.who     = who;
            e.fin     = fin;
            lock_events_q.push_back(e);
        endfunction

        function void take_lock(t_task_id t);
            owner_valid = 1'b1;
            owner       = t;
            depth       = recursive ? 1 : 0;
        endfunction

        // Pops the head writer and makes it the owner.
        function t_task_id hand_to_head();
            t_task_id t;
            t = wq[q_head];
            q_head++;
            q_fill--;
            take_lock(t);
            return t;
        endfunction

        // Updates the lock state for one accepted request and queues its results.
        function void note_request(rwl_pkg::t_command cmd, t_task_id t);
            int unsigned before_n;
            int unsigned d;
            before_n = lock_events_q.size();
            requests++;
            if (blocked(t)) begin
                push(rwl_pkg::EV_ERROR, t, 1'b1);
            end else begin
                case (cmd)
                    rwl_pkg::CMD_SH_ACQUIRE: begin
                        if (writers > 0) begin
                            waiting[t] = 1'b1;
                            push(rwl_pkg::EV_WAIT, t, 1'b1);
                        end else if (readers >= rwl_pkg::COUNT_MAX) begin
                            push(rwl_pkg::EV_ERROR, t, 1'b1);
                        end else begin
                            readers++;
                            push(rwl_pkg::EV_GRANT, t, 1'b1);
                        end
                    end
                    rwl_pkg::CMD_SH_RELEASE: begin
                        if (readers == 0) begin
                            push(rwl_pkg::EV_ERROR, t, 1'b1);
                        end else begin
                            readers--;
                            // The last reader leaving passes the lock to a queued writer.
                            if (readers == 0 && writers > 0 && q_fill > 0 && !owner_valid) begin
                                push(rwl_pkg::EV_DONE, t, 1'b0);
                                push(rwl_pkg::EV_WOKEN, hand_to_head(), 1'b1);
                            end else begin
                                push(rwl_pkg::EV_DONE, t, 1'b1);
                            end
                        end
                    end
                    rwl_pkg::CMD_EX_ACQUIRE: begin
                        if (owner_valid && owner == t) begin
                            d = (depth == 0) ? 1 : depth;
                            if (!recursive || d >= rwl_pkg::MAX_RECURSION) begin
                                push(rwl_pkg::EV_ERROR, t, 1'b1);
                            end else begin
                                depth = d + 1;
                                push(rwl_pkg::EV_GRANT, t, 1'b1);
                            end
                        end else if (writers >= rwl_pkg::COUNT_MAX
                                     || q_fill >= rwl_pkg::NUM_TASKS) begin
                            push(rwl_pkg::EV_ERROR, t, 1'b1);
                        end else begin
                            writers++;
                            if (!owner_valid && readers == 0 && q_fill == 0) begin
                                take_lock(t);
                                push(rwl_pkg::EV_GRANT, t, 1'b1);
                            end else begin
                                wq[rwl_pkg::TASK_W'(q_head + q_fill)] = t;
                                q_fill++;
                                push(rwl_pkg::EV_WAIT, t, 1'b1);
                            end
                        end
                    end
                    rwl_pkg::CMD_EX_RELEASE: begin
                        if (!owner_valid || owner != t) begin
                            push(rwl_pkg::EV_ERROR, t, 1'b1);
                        end else if (recursive && depth > 1) begin
                            depth--;
                            push(rwl_pkg::EV_DONE, t, 1'b1);
                        end else begin
                            owner_valid = 1'b0;
                            owner       = '0;
                            depth       = 0;
                            if (writers > 0) writers--;
                            if (q_fill > 0) begin
                                push(rwl_pkg::EV_DONE, t, 1'b0);
                                push(rwl_pkg::EV_WOKEN, hand_to_head(), 1'b1);
                            end else if (waiting == '0) begin
                                push(rwl_pkg::EV_DONE, t, 1'b1);
                            end else begin
                                // Every waiting reader is woken, lowest task first.
                                push(rwl_pkg::EV_DONE, t, 1'b0);
                                for (int i = 0; i < rwl_pkg::NUM_TASKS; i++) begin
                                    if (waiting[i]) begin
                                        waiting[i] = 1'b0;
                                        if (readers < rwl_pkg::COUNT_MAX) readers++;
                                        push(rwl_pkg::EV_WOKEN, rwl_pkg::TASK_W'(i),
                                             (waiting == '0));
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            if (lock_events_q.size() - before_n > widest) widest = lock_events_q.size() - before_n;
        endfunction

        task flag(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [rwl_pkg::EVENT_W-1:0] ev, t_task_id who, logic fin);
            t_lock_event e;
            results_seen++;
            if (lock_events_q.size() == 0) begin
                flag($sformatf("unexpected result event %0d task %0d last %0d", ev, who, fin));
            end else begin
                e = lock_events_q.pop_front();
                if (e.ev_code == rwl_pkg::EV_ERROR) errors_seen++;
                if (ev !== e.ev_code)
                    flag($sformatf("event %0d, expected %s for task %0d",
                                   ev, e.ev_code.name(), e.who));
                if (who !== e.who)
                    flag($sformatf("task %0d, expected %0d on %s", who, e.who, e.ev_code.name()));
                if (fin !== e.fin)
                    flag($sformatf("last %0d, expected %0d on %s task %0d",
                                   fin, e.fin, e.ev_code.name(), e.who));
            end
        endtask

        task close_out();
            if (lock_events_q.size() != 0)
                flag($sformatf("%0d results never arrived", lock_events_q.size()));
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            hold_res;
    int unsigned     cycle_cnt;
    int unsigned     tx_gap_max;
    int unsigned     rx_gap_max;
    lock_scoreboard  sb;

    rwl_req_if req_ch ();
    rwl_res_if res_ch ();
    rwl_cfg_if cfg_ch ();

    writer_preferring_rwlock_arbiter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: a random stall before each result, and once a long hold-off
    // so that the output register and the input stage both fill up.
    initial begin
        int unsigned gap;
        res_ch.ready <= 1'b0;
        hold_res     <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_res) begin
                hold_res     <= 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = $urandom_range(rx_gap_max, 0);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.event_res, res_ch.task_res, res_ch.last);
    end

    // Offers one request after a random gap and notes it once it is accepted.
    task automatic offer_request(rwl_pkg::t_command cmd, t_task_id who);
        int unsigned gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.requester <= who;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(cmd, who);
    endtask

    // The block is idle once every expected result has been taken.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(bit mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.recursive = mode;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int unsigned free_count();
        int unsigned n;
        n = 0;
        for (int t = 0; t < rwl_pkg::NUM_TASKS; t++) begin
            if (!sb.blocked(rwl_pkg::TASK_W'(t))) n++;
        end
        return n;
    endfunction

    // A random task that is neither waiting nor queued, the owner optionally excluded.
    function automatic t_task_id pick_free(bit allow_owner);
        int       start;
        t_task_id t;
        start = $urandom_range(rwl_pkg::NUM_TASKS - 1, 0);
        for (int k = 0; k < rwl_pkg::NUM_TASKS; k++) begin
            t = rwl_pkg::TASK_W'(start + k);
            if (!sb.blocked(t) && (allow_owner || !(sb.owner_valid && sb.owner == t))) return t;
        end
        return rwl_pkg::TASK_W'(start);
    endfunction

    // Mostly well-formed lock traffic driven by the current lock state, with some
    // noise. Tasks are never all tied up waiting, and the owner never asks for
    // shared access here, since that would hold the lock for good.
    task automatic send_random();
        int unsigned       r;
        rwl_pkg::t_command cmd;
        t_task_id          who;
        r = $urandom_range(99, 0);
        if (r < 12 && free_count() > 5) begin
            cmd = rwl_pkg::t_command'($urandom_range(3, 0));
            who = rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0));
            if (cmd == rwl_pkg::CMD_SH_ACQUIRE && sb.owner_valid && who == sb.owner)
                cmd = rwl_pkg::CMD_SH_RELEASE;
        end else if (sb.owner_valid && r < 40) begin
            who = sb.owner;
            cmd = ($urandom_range(2, 0) == 0) ? rwl_pkg::CMD_EX_ACQUIRE
                                              : rwl_pkg::CMD_EX_RELEASE;
        end else if (sb.readers > 0 && r < 62) begin
            who = pick_free(1'b1);
            cmd = rwl_pkg::CMD_SH_RELEASE;
        end else if (r < 82 && (sb.writers == 0 || free_count() > 5)) begin
            who = pick_free(1'b0);
            cmd = rwl_pkg::CMD_SH_ACQUIRE;
        end else if (free_count() > 5 || (!sb.owner_valid && sb.readers == 0)) begin
            who = pick_free(1'b0);
            cmd = rwl_pkg::CMD_EX_ACQUIRE;
        end else if (sb.owner_valid) begin
            who = sb.owner;
            cmd = rwl_pkg::CMD_EX_RELEASE;
        end else begin
            who = pick_free(1'b1);
            cmd = rwl_pkg::CMD_SH_RELEASE;
        end
        offer_request(cmd, who);
    endtask

    // Releases everything until the lock is free with no one waiting.
    task automatic drain_lock();
        int guard;
        guard = 0;
        while ((sb.owner_valid || sb.readers != 0 || sb.writers != 0 || sb.waiting != '0)
               && guard < rwl_pkg::MAX_RECURSION + 64) begin
            if (sb.owner_valid) offer_request(rwl_pkg::CMD_EX_RELEASE, sb.owner);
            else if (sb.readers != 0) offer_request(rwl_pkg::CMD_SH_RELEASE, pick_free(1'b1));
            else guard = rwl_pkg::MAX_RECURSION + 64;
            guard++;
        end
    endtask

    // One writer holds the lock while every other task queues for shared access;
    // its release then wakes all of them in one long burst.
    task automatic wake_all_readers();
        t_task_id w;
        drain_lock();
        w = rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0));
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, w);
        for (int t = 0; t < rwl_pkg::NUM_TASKS; t++) begin
            if (rwl_pkg::TASK_W'(t) != w)
                offer_request(rwl_pkg::CMD_SH_ACQUIRE, rwl_pkg::TASK_W'(t));
        end
        offer_request(rwl_pkg::CMD_EX_RELEASE, w);
        drain_lock();
    endtask

    // Fills the reader count to saturation and empties it past zero.
    task automatic flood_readers();
        drain_lock();
        repeat (rwl_pkg::COUNT_MAX + 1)
            offer_request(rwl_pkg::CMD_SH_ACQUIRE,
                          rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0)));
        repeat (rwl_pkg::COUNT_MAX + 1)
            offer_request(rwl_pkg::CMD_SH_RELEASE,
                          rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0)));
    endtask

    // The owner nests several re-acquires; the lock is then freed by a single
    // release after recursion is switched off.
    task automatic deep_recursion();
        t_task_id w;
        drain_lock();
        wait_idle();
        write_mode(1'b1);
        w = rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0));
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, w);
        repeat (NEST_DEPTH) offer_request(rwl_pkg::CMD_EX_ACQUIRE, w);
        wait_idle();
        write_mode(1'b0);
        offer_request(rwl_pkg::CMD_EX_RELEASE, w);
    endtask

    initial begin
        t_task_id w;
        sb = new();
        tx_gap_max = 17;
        rx_gap_max = 17;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= rwl_pkg::CMD_SH_ACQUIRE;
        req_ch.requester <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // Directed part without recursion: errors on an empty lock, readers
        // holding off queued writers, blocked requesters, hand-off from the last
        // reader, a refused re-acquire, foreign releases and a reader wake-up.
        offer_request(rwl_pkg::CMD_SH_RELEASE, 4'd0);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd15);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, 4'd0);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, 4'd15);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd3);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, 4'd5);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, 4'd5);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd3);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd7);
        offer_request(rwl_pkg::CMD_SH_RELEASE, 4'd1);
        offer_request(rwl_pkg::CMD_SH_RELEASE, 4'd2);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd3);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd9);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, 4'd10);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd3);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd7);
        offer_request(rwl_pkg::CMD_SH_RELEASE, 4'd0);
        offer_request(rwl_pkg::CMD_SH_RELEASE, 4'd0);

        // Directed part with recursion: nested acquire and unwinding.
        wait_idle();
        write_mode(1'b1);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd12);
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, 4'd12);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd12);
        offer_request(rwl_pkg::CMD_EX_RELEASE, 4'd12);

        // Random part in chunks, each with its own mode and idling pattern.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            wait_idle();
            write_mode(chunk[0]);
            case (chunk)
                0: begin tx_gap_max = 17; rx_gap_max = 17; end
                1: begin tx_gap_max = 0;  rx_gap_max = 0;  end
                2: begin tx_gap_max = 3;  rx_gap_max = 17; end
                default: begin tx_gap_max = 17; rx_gap_max = 0; end
            endcase
            if (chunk == 1) hold_res <= 1'b1;
            repeat (RANDOM_PER_CHUNK) send_random();
            if (chunk == 2) flood_readers();
            else if (chunk != 0) wake_all_readers();
        end
        tx_gap_max = 5;
        rx_gap_max = 5;
        deep_recursion();

        // Last of all, the owner asks for shared access: it waits behind itself
        // and its own release is then refused, so the lock stays held.
        drain_lock();
        w = rwl_pkg::TASK_W'($urandom_range(rwl_pkg::NUM_TASKS - 1, 0));
        offer_request(rwl_pkg::CMD_EX_ACQUIRE, w);
        offer_request(rwl_pkg::CMD_SH_ACQUIRE, w);
        offer_request(rwl_pkg::CMD_EX_RELEASE, w);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.close_out();
        $display("Ran %0d requests giving %0d results, %0d of them errors; widest burst %0d.",
                 sb.requests, sb.results_seen, sb.errors_seen, sb.widest);
        $display("Both recursion modes, reader saturation, nested re-acquires and a long stall ran.");
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
